@@ rtl/sra_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Stale-reclaim slot allocator package
// Shared types and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
package sra_pkg;

    localparam int unsigned FUNC_W     = 1;
    localparam int unsigned SLOT_W     = 4;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned MASK_W     = 16;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd15000;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    typedef struct packed {
        logic load;
        logic commit;
    } cmd_t;

endpackage
`default_nettype wire

@@ rtl/sra_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Stale-reclaim slot allocator controller
// Sequences one request at a time through capture and commit, and owns the
// input stall and the valid flag of the result register.
// ----------------------------------------------------------------------------
module sra_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  wire logic        out_stall,
    output sra_pkg::cmd_t    cmd
);
    import sra_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd.load       = 1'b0;
        cmd.commit     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_load_then_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_SCAN))
        else $error("Accepted beat did not move the controller to the scan step.");

    a_rise_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.commit))
        else $error("Result became valid without a commit.");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || !out_stall))
        else $error("Commit would overwrite a result still waiting.");

endmodule
`default_nettype wire

@@ rtl/sra_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Stale-reclaim slot allocator datapath
// Holds the in-use map, the allocation stamps and the timeout. Ages are
// compared against every stamp when a request is captured; the commit step
// priority-encodes the first free or stale slot and updates the map.
// ----------------------------------------------------------------------------
module sra_datapath #(
    parameter int SLOTS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sra_pkg::cmd_t                 cmd,
    input  wire logic                          cfg_wr_en,
    input  wire logic [sra_pkg::TIME_W-1:0]    cfg_wr_data,
    input  wire logic [sra_pkg::FUNC_W-1:0]    func,
    input  wire logic [sra_pkg::SLOT_W-1:0]    slot,
    input  wire logic [sra_pkg::TIME_W-1:0]    now_time,
    output logic                               granted,
    output logic [sra_pkg::SLOT_W-1:0]         slot_index,
    output logic [sra_pkg::MASK_W-1:0]         reclaimed_mask
);
    import sra_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [TIME_W-1:0] timeout_reg;
    logic [SLOTS-1:0]  in_use_reg;
    logic [SLOTS-1:0]  in_use_next;
    logic [TIME_W-1:0] stamp_reg [SLOTS];
    logic [SLOTS-1:0]  stale_reg;
    logic [SLOTS-1:0]  stale_next;
    logic [FUNC_W-1:0] func_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [TIME_W-1:0] now_reg;

    logic              granted_reg;
    logic              granted_next;
    logic [SLOT_W-1:0] slot_index_reg;
    logic [SLOT_W-1:0] slot_index_next;
    logic [MASK_W-1:0] reclaimed_reg;
    logic [MASK_W-1:0] reclaimed_next;

    logic [SLOTS-1:0]  cand;
    logic              found;
    logic [IDX_W-1:0]  idx;
    logic [SLOTS-1:0]  idx_onehot;
    logic              do_grant;
    logic              free_in_range;

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            stale_next[i] = (now_time - stamp_reg[i]) > timeout_reg;
        end
    end

    always_comb
    begin
        found = 1'b0;
        idx   = '0;
        cand  = ~in_use_reg | stale_reg;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                found = 1'b1;
                idx   = IDX_W'(i);
            end
        end
    end

    assign do_grant      = (func_reg == FUNC_ALLOC) && found;
    assign free_in_range = (32'(slot_reg) < SLOTS);

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            idx_onehot[i] = (idx == IDX_W'(i));
        end
    end

    always_comb
    begin
        in_use_next     = in_use_reg;
        granted_next    = 1'b0;
        slot_index_next = '0;
        reclaimed_next  = '0;
        if (func_reg == FUNC_FREE)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (free_in_range && (32'(slot_reg) == i))
                begin
                    in_use_next[i] = 1'b0;
                end
            end
        end
        else if (do_grant)
        begin
            in_use_next     = in_use_reg | idx_onehot;
            granted_next    = 1'b1;
            slot_index_next = SLOT_W'(idx);
            reclaimed_next  = MASK_W'(idx_onehot & in_use_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            in_use_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
            if (cmd.commit)
            begin
                in_use_reg <= in_use_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= func;
            slot_reg  <= slot;
            now_reg   <= now_time;
            stale_reg <= stale_next;
        end
        if (cmd.commit)
        begin
            granted_reg    <= granted_next;
            slot_index_reg <= slot_index_next;
            reclaimed_reg  <= reclaimed_next;
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            if (cmd.commit && do_grant && idx_onehot[i])
            begin
                stamp_reg[i] <= now_reg;
            end
        end
    end

    assign granted        = granted_reg;
    assign slot_index     = slot_index_reg;
    assign reclaimed_mask = reclaimed_reg;

endmodule
`default_nettype wire

@@ rtl/stale_reclaim_slot_allocator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Stale-reclaim slot allocator
// Each request has a capture step, which registers the age compare of the
// request time against every slot's stamp, and a commit step, which waits
// until the result register is free, priority-encodes the first free or stale
// slot for an alloc (a free clears the named slot), updates the map and loads
// the result register. A new request is stalled until the previous one commits.
// The result register lets a new request enter while the previous result
// still waits. Stamps need no clearing after reset; one is read only for a
// slot that is in use. The timeout may be written only while the block is idle.
// ----------------------------------------------------------------------------
module stale_reclaim_slot_allocator #(
    parameter int SLOTS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [sra_pkg::TIME_W-1:0]    cfg_wr_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [sra_pkg::FUNC_W-1:0]    func,
    input  wire logic [sra_pkg::SLOT_W-1:0]    slot,
    input  wire logic [sra_pkg::TIME_W-1:0]    now_time,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               granted,
    output logic [sra_pkg::SLOT_W-1:0]         slot_index,
    output logic [sra_pkg::MASK_W-1:0]         reclaimed_mask
);
    import sra_pkg::*;

    cmd_t cmd;

    sra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    sra_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .func           (func),
        .slot           (slot),
        .now_time       (now_time),
        .granted        (granted),
        .slot_index     (slot_index),
        .reclaimed_mask (reclaimed_mask)
    );

endmodule
`default_nettype wire
